/* rtl/core/pmfr_pkg.sv */
// Shared types, constants and helpers for the particulate sensor frame receiver.
// No dependencies.
package pmfr_pkg;

    localparam int FRAME_BYTES  = 32;
    localparam int NUM_READINGS = 12;
    localparam int QUEUE_DEPTH  = 4;

    localparam int POS_W  = $clog2(FRAME_BYTES);
    localparam int RIDX_W = $clog2(NUM_READINGS);
    localparam int SLOT_W = (POS_W > RIDX_W) ? POS_W : RIDX_W;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  HDR_FIRST     = 8'h42;
    localparam logic [7:0]  HDR_SECOND    = 8'h4D;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam int          READING_BASE  = 4;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_MASS  = 2'd0,
        KIND_COUNT = 2'd1,
        KIND_ALL   = 2'd2,
        KIND_BAD   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CT_NONE     = 2'd0,
        CT_STANDARD = 2'd1,
        CT_ENV      = 2'd2,
        CT_BAD      = 2'd3
    } ctype_t;

    localparam logic [2:0] SIZE_1P0 = 3'd3;
    localparam logic [2:0] SIZE_2P5 = 3'd4;
    localparam logic [2:0] SIZE_10  = 3'd6;
    localparam logic [2:0] SIZE_MIN = 3'd1;
    localparam logic [2:0] SIZE_MAX = 3'd6;

    localparam logic [RIDX_W-1:0] IDX_STD_BASE   = RIDX_W'(0);
    localparam logic [RIDX_W-1:0] IDX_ENV_BASE   = RIDX_W'(3);
    localparam logic [RIDX_W-1:0] IDX_COUNT_OFFS = RIDX_W'(5);
    localparam logic [RIDX_W-1:0] IDX_LAST       = RIDX_W'(NUM_READINGS - 1);

    typedef enum logic [2:0] {
        ST_VALUE       = 3'd0,
        ST_FRAME_OK    = 3'd1,
        ST_CSUM_ERR    = 3'd2,
        ST_TIMEOUT     = 3'd3,
        ST_UNSUPPORTED = 3'd4,
        ST_NO_DATA     = 3'd5
    } status_t;

    typedef struct packed {
        logic              all;
        status_t           status;
        logic [RIDX_W-1:0] index;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    typedef logic [NUM_READINGS-1:0][15:0] readings_t;

    // true when both bytes of reading i lie before the trailer
    function automatic logic reading_in_frame(input int i);
        return (READING_BASE + 2 * i + 1) < (FRAME_BYTES - 2);
    endfunction

endpackage

/* rtl/core/pmfr_queue.sv */
// Short job queue between front and back of the frame receiver.
// Depends on pmfr_pkg.
module pmfr_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  pmfr_pkg::push_t push,
    input  logic          pop,
    output pmfr_pkg::job_t head,
    output logic          head_valid,
    output logic          empty,
    output logic          full
);

    pmfr_pkg::job_t                 mem [pmfr_pkg::QUEUE_DEPTH];
    logic [pmfr_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [pmfr_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [pmfr_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [pmfr_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [pmfr_pkg::QCNT_W-1:0]    count_reg;
    logic [pmfr_pkg::QCNT_W-1:0]    count_next;
    logic                           do_push;
    logic                           do_pop;

    assign empty      = (count_reg == '0);
    assign full       = (count_reg == pmfr_pkg::QCNT_W'(pmfr_pkg::QUEUE_DEPTH));
    assign head_valid = !empty;
    assign head       = mem[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == pmfr_pkg::QPTR_W'(pmfr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == pmfr_pkg::QPTR_W'(pmfr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.job;
        end
    end

endmodule

/* rtl/core/pmfr_front.sv */
// Front end: accepts beats, hunts headers, assembles and checks frames,
// counts ticks, classifies queries and pushes result jobs. Depends on pmfr_pkg.
module pmfr_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    timeout_ticks_we,
    input  logic [15:0]             timeout_ticks_wdata,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              opcode,
    input  logic [7:0]              rx_byte,
    input  logic [1:0]              metric_kind,
    input  logic [1:0]              concentration_type,
    input  logic [2:0]              particle_size,
    input  logic                    q_empty,
    input  logic                    q_full,
    output pmfr_pkg::push_t         push,
    output logic                    latch,
    output pmfr_pkg::readings_t     latched
);

    logic [15:0]                    timeout_reg;
    logic [pmfr_pkg::POS_W-1:0]     pos_reg;
    logic [pmfr_pkg::POS_W-1:0]     pos_next;
    logic [15:0]                    sum_reg;
    logic [15:0]                    sum_next;
    logic [15:0]                    tick_reg;
    logic [15:0]                    tick_next;
    logic [15:0]                    tick_inc;
    logic [7:0]                     trailer_hi_reg;
    logic                           have_frame_reg;
    logic                           have_frame_next;
    pmfr_pkg::readings_t            staging_reg;
    pmfr_pkg::readings_t            latched_reg;
    logic                           accept;
    logic                           frame_end;
    logic                           hdr_fail;
    logic [pmfr_pkg::SLOT_W-1:0]    slot;
    logic                           csum_ok;

    always_comb
    begin
        frame_end = (pmfr_pkg::opcode_t'(opcode) == pmfr_pkg::OP_BYTE)
                 && (pos_reg == pmfr_pkg::POS_W'(pmfr_pkg::FRAME_BYTES - 1));
        in_ready  = !q_full && !(frame_end && !q_empty);
        accept    = in_valid && in_ready;
        hdr_fail  = ((pos_reg == pmfr_pkg::POS_W'(0)) && (rx_byte != pmfr_pkg::HDR_FIRST))
                 || ((pos_reg == pmfr_pkg::POS_W'(1)) && (rx_byte != pmfr_pkg::HDR_SECOND));
        slot      = (pmfr_pkg::SLOT_W'(pos_reg) - pmfr_pkg::SLOT_W'(pmfr_pkg::READING_BASE)) >> 1;
        csum_ok   = ({trailer_hi_reg, rx_byte} == sum_reg);
        tick_inc  = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;
    end

    always_comb
    begin
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        tick_next       = tick_reg;
        have_frame_next = have_frame_reg;
        latch           = 1'b0;
        push            = '0;
        if (accept)
        begin
            case (pmfr_pkg::opcode_t'(opcode))
                pmfr_pkg::OP_BYTE:
                begin
                    if (hdr_fail)
                    begin
                        pos_next = '0;
                        sum_next = '0;
                    end
                    else if (frame_end)
                    begin
                        pos_next       = '0;
                        sum_next       = '0;
                        tick_next      = '0;
                        push.valid     = 1'b1;
                        push.job.index = '0;
                        if (csum_ok)
                        begin
                            latch           = 1'b1;
                            have_frame_next = 1'b1;
                            push.job.status = pmfr_pkg::ST_FRAME_OK;
                        end
                        else
                        begin
                            push.job.status = pmfr_pkg::ST_CSUM_ERR;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                        if ((32'(pos_reg) + 2) < pmfr_pkg::FRAME_BYTES)
                        begin
                            sum_next = sum_reg + 16'(rx_byte);
                        end
                    end
                end
                pmfr_pkg::OP_TICK:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= timeout_reg)
                    begin
                        pos_next        = '0;
                        sum_next        = '0;
                        tick_next       = '0;
                        push.valid      = 1'b1;
                        push.job.status = pmfr_pkg::ST_TIMEOUT;
                    end
                end
                pmfr_pkg::OP_QUERY:
                begin
                    push.valid      = 1'b1;
                    push.job.status = pmfr_pkg::ST_UNSUPPORTED;
                    if (!have_frame_reg)
                    begin
                        push.job.status = pmfr_pkg::ST_NO_DATA;
                    end
                    else if (pmfr_pkg::kind_t'(metric_kind) == pmfr_pkg::KIND_ALL)
                    begin
                        push.job.all    = 1'b1;
                        push.job.status = pmfr_pkg::ST_VALUE;
                    end
                    else if (pmfr_pkg::kind_t'(metric_kind) == pmfr_pkg::KIND_MASS
                          && (pmfr_pkg::ctype_t'(concentration_type) == pmfr_pkg::CT_STANDARD
                           || pmfr_pkg::ctype_t'(concentration_type) == pmfr_pkg::CT_ENV))
                    begin
                        push.job.index = (pmfr_pkg::ctype_t'(concentration_type)
                                          == pmfr_pkg::CT_STANDARD)
                                       ? pmfr_pkg::IDX_STD_BASE : pmfr_pkg::IDX_ENV_BASE;
                        if (particle_size == pmfr_pkg::SIZE_1P0)
                        begin
                            push.job.status = pmfr_pkg::ST_VALUE;
                        end
                        else if (particle_size == pmfr_pkg::SIZE_2P5)
                        begin
                            push.job.status = pmfr_pkg::ST_VALUE;
                            push.job.index  = push.job.index + pmfr_pkg::RIDX_W'(1);
                        end
                        else if (particle_size == pmfr_pkg::SIZE_10)
                        begin
                            push.job.status = pmfr_pkg::ST_VALUE;
                            push.job.index  = push.job.index + pmfr_pkg::RIDX_W'(2);
                        end
                        else
                        begin
                            push.job.index = '0;
                        end
                    end
                    else if (pmfr_pkg::kind_t'(metric_kind) == pmfr_pkg::KIND_COUNT
                          && particle_size >= pmfr_pkg::SIZE_MIN
                          && particle_size <= pmfr_pkg::SIZE_MAX)
                    begin
                        push.job.status = pmfr_pkg::ST_VALUE;
                        push.job.index  = pmfr_pkg::RIDX_W'(particle_size)
                                        + pmfr_pkg::IDX_COUNT_OFFS;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= pmfr_pkg::TIMEOUT_RESET;
            pos_reg        <= '0;
            sum_reg        <= '0;
            tick_reg       <= '0;
            have_frame_reg <= 1'b0;
        end
        else
        begin
            if (timeout_ticks_we)
            begin
                timeout_reg <= timeout_ticks_wdata;
            end
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            tick_reg       <= tick_next;
            have_frame_reg <= have_frame_next;
        end
    end

    // frame payload, captured per beat and copied out on a good checksum
    always_ff @(posedge clk)
    begin
        if (accept && pmfr_pkg::opcode_t'(opcode) == pmfr_pkg::OP_BYTE && !hdr_fail)
        begin
            if (pos_reg == pmfr_pkg::POS_W'(pmfr_pkg::FRAME_BYTES - 2))
            begin
                trailer_hi_reg <= rx_byte;
            end
            if (32'(pos_reg) >= pmfr_pkg::READING_BASE
                && 32'(slot) < pmfr_pkg::NUM_READINGS)
            begin
                if (pos_reg[0])
                begin
                    staging_reg[slot[pmfr_pkg::RIDX_W-1:0]][7:0] <= rx_byte;
                end
                else
                begin
                    staging_reg[slot[pmfr_pkg::RIDX_W-1:0]][15:8] <= rx_byte;
                end
            end
        end
        if (latch)
        begin
            for (int i = 0; i < pmfr_pkg::NUM_READINGS; i++)
            begin
                latched_reg[i] <= pmfr_pkg::reading_in_frame(i) ? staging_reg[i] : 16'd0;
            end
        end
    end

    assign latched = latched_reg;

endmodule

/* rtl/core/pmfr_back.sv */
// Back end: expands queued jobs into result beats and holds the output register.
// Depends on pmfr_pkg.
module pmfr_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  pmfr_pkg::job_t              head,
    input  logic                        head_valid,
    output logic                        pop,
    input  pmfr_pkg::readings_t         latched,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  status,
    output logic [15:0]                 reading,
    output logic [3:0]                  reading_index,
    output logic                        last
);

    logic                           valid_reg;
    logic [2:0]                     status_reg;
    logic [15:0]                    reading_reg;
    logic [3:0]                     index_reg;
    logic                           last_reg;
    logic [pmfr_pkg::RIDX_W-1:0]    cnt_reg;
    logic [pmfr_pkg::RIDX_W-1:0]    cnt_next;
    logic                           load;
    logic [pmfr_pkg::RIDX_W-1:0]    sel_index;
    logic                           sel_last;

    always_comb
    begin
        load      = head_valid && (!valid_reg || out_ready);
        sel_index = head.all ? cnt_reg : head.index;
        sel_last  = !head.all || (cnt_reg == pmfr_pkg::IDX_LAST);
        pop       = load && sel_last;
        cnt_next  = cnt_reg;
        if (load && head.all)
        begin
            cnt_next = sel_last ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg  <= head.status;
            last_reg    <= sel_last;
            if (head.status == pmfr_pkg::ST_VALUE)
            begin
                reading_reg <= latched[sel_index];
                index_reg   <= 4'(sel_index);
            end
            else
            begin
                reading_reg <= '0;
                index_reg   <= '0;
            end
        end
    end

    assign out_valid     = valid_reg;
    assign status        = status_reg;
    assign reading       = reading_reg;
    assign reading_index = index_reg;
    assign last          = last_reg;

endmodule

/* rtl/core/particulate_sensor_frame_receiver_core.sv */
// Path: an accepted beat's job is written into the job queue, then loaded into the
// back-end output register that drives out_valid.
// Throughput: one beat per cycle; an all-readings query emits twelve results
// from the back end; input stalls while the four-entry job queue is full,
// and the frame-final byte waits until the queue has drained (it rewrites the readings).
// Reset: control state cleared, timeout_ticks to 1000; frame and reading stores
// hold no reset value and are never read before being written.
module particulate_sensor_frame_receiver_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        timeout_ticks_we,
    input  logic [15:0] timeout_ticks_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  rx_byte,
    input  logic [1:0]  metric_kind,
    input  logic [1:0]  concentration_type,
    input  logic [2:0]  particle_size,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] reading,
    output logic [3:0]  reading_index,
    output logic        last
);

    pmfr_pkg::push_t        push;
    pmfr_pkg::job_t         head;
    pmfr_pkg::readings_t    latched;
    logic                   head_valid;
    logic                   pop;
    logic                   q_empty;
    logic                   q_full;
    logic                   latch;

    pmfr_front u_front
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .timeout_ticks_we    (timeout_ticks_we),
        .timeout_ticks_wdata (timeout_ticks_wdata),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .opcode              (opcode),
        .rx_byte             (rx_byte),
        .metric_kind         (metric_kind),
        .concentration_type  (concentration_type),
        .particle_size       (particle_size),
        .q_empty             (q_empty),
        .q_full              (q_full),
        .push                (push),
        .latch               (latch),
        .latched             (latched)
    );

    pmfr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .empty      (q_empty),
        .full       (q_full)
    );

    pmfr_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop),
        .latched       (latched),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .reading       (reading),
        .reading_index (reading_index),
        .last          (last)
    );

    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !q_full)
        else $error("job pushed into full queue");

    a_latch_idle : assert property (@(posedge clk) disable iff (!rst_n)
        latch |-> (q_empty && !head_valid))
        else $error("readings rewritten while jobs pending");

    a_multi_is_value : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (status == pmfr_pkg::ST_VALUE))
        else $error("non-final beat carries a non-value status");

endmodule

/* bench/tb_particulate_sensor_frame_receiver_core.sv */
`timescale 1ns / 1ps
// Testbench for particulate_sensor_frame_receiver_core: directed and random beats
// checked against an in-bench predictor of frame parsing, timeouts and queries.
// Depends on pmfr_pkg and the core module only.
module tb_particulate_sensor_frame_receiver_core;

    localparam int RANDOM_ITEMS   = 320;
    localparam int HOLD_OFF       = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

    typedef struct {
        pmfr_pkg::status_t st;
        logic [15:0]       value;
        logic [3:0]        idx;
        logic              fin;
    } report_t;

    logic        clk;
    logic        rst_n;
    logic        timeout_ticks_we;
    logic [15:0] timeout_ticks_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [7:0]  rx_byte;
    logic [1:0]  metric_kind;
    logic [1:0]  concentration_type;
    logic [2:0]  particle_size;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [15:0] reading;
    logic [3:0]  reading_index;
    logic        last;

    // predictor state
    int          rx_pos;
    logic [7:0]  rx_frame [pmfr_pkg::FRAME_BYTES];
    logic [15:0] rx_sum;
    logic [15:0] latched [pmfr_pkg::NUM_READINGS];
    bit          have_frame;
    logic [15:0] tick_count;
    logic [15:0] timeout_limit;

    report_t     pending_reports [$];
    report_t     head;
    logic [7:0]  frame_img [pmfr_pkg::FRAME_BYTES];

    bit          idling;
    int          hold_off_req;
    int          sent_items;
    int          result_beats;
    int          mismatches;
    int          good_frames;
    int          bad_frames;
    int          timeouts;
    int          quiet;

    particulate_sensor_frame_receiver_core dut
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .timeout_ticks_we    (timeout_ticks_we),
        .timeout_ticks_wdata (timeout_ticks_wdata),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .opcode              (opcode),
        .rx_byte             (rx_byte),
        .metric_kind         (metric_kind),
        .concentration_type  (concentration_type),
        .particle_size       (particle_size),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .status              (status),
        .reading             (reading),
        .reading_index       (reading_index),
        .last                (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void queue_report(pmfr_pkg::status_t st, logic [15:0] value,
                                         logic [3:0] idx, logic fin);
        report_t r;
        r.st    = st;
        r.value = value;
        r.idx   = idx;
        r.fin   = fin;
        pending_reports.push_back(r);
    endfunction

    function automatic void restart_frame();
        rx_pos     = 0;
        rx_sum     = '0;
        tick_count = '0;
    endfunction

    function automatic void predict_reports(pmfr_pkg::opcode_t op, logic [7:0] b,
                                            pmfr_pkg::kind_t kind, pmfr_pkg::ctype_t ct,
                                            logic [2:0] sz);
        logic [15:0] trailer;
        int          sel;
        int          hi;
        logic [3:0]  base;
        case (op)
            pmfr_pkg::OP_BYTE:
            begin
                if ((rx_pos == 0 && b != pmfr_pkg::HDR_FIRST) ||
                    (rx_pos == 1 && b != pmfr_pkg::HDR_SECOND))
                begin
                    rx_pos = 0;
                    rx_sum = '0;
                end
                else
                begin
                    rx_frame[rx_pos] = b;
                    if (rx_pos + 2 < pmfr_pkg::FRAME_BYTES)
                        rx_sum = rx_sum + 16'(b);
                    rx_pos++;
                    if (rx_pos == pmfr_pkg::FRAME_BYTES)
                    begin
                        trailer = {rx_frame[pmfr_pkg::FRAME_BYTES-2],
                                   rx_frame[pmfr_pkg::FRAME_BYTES-1]};
                        if (trailer == rx_sum)
                        begin
                            for (int i = 0; i < pmfr_pkg::NUM_READINGS; i++)
                            begin
                                hi = pmfr_pkg::READING_BASE + 2 * i;
                                if (hi + 1 < pmfr_pkg::FRAME_BYTES - 2)
                                    latched[i] = {rx_frame[hi], rx_frame[hi+1]};
                                else
                                    latched[i] = '0;
                            end
                            have_frame = 1'b1;
                            good_frames++;
                            queue_report(pmfr_pkg::ST_FRAME_OK, '0, '0, 1'b1);
                        end
                        else
                        begin
                            bad_frames++;
                            queue_report(pmfr_pkg::ST_CSUM_ERR, '0, '0, 1'b1);
                        end
                        restart_frame();
                    end
                end
            end
            pmfr_pkg::OP_TICK:
            begin
                if (tick_count != 16'hFFFF)
                    tick_count++;
                if (tick_count >= timeout_limit)
                begin
                    restart_frame();
                    timeouts++;
                    queue_report(pmfr_pkg::ST_TIMEOUT, '0, '0, 1'b1);
                end
            end
            pmfr_pkg::OP_QUERY:
            begin
                sel = -1;
                if (!have_frame)
                    queue_report(pmfr_pkg::ST_NO_DATA, '0, '0, 1'b1);
                else if (kind == pmfr_pkg::KIND_ALL)
                begin
                    for (int i = 0; i < pmfr_pkg::NUM_READINGS; i++)
                        queue_report(pmfr_pkg::ST_VALUE, latched[i], 4'(i),
                                     i == pmfr_pkg::NUM_READINGS - 1);
                end
                else
                begin
                    if (kind == pmfr_pkg::KIND_MASS &&
                        (ct == pmfr_pkg::CT_STANDARD || ct == pmfr_pkg::CT_ENV))
                    begin
                        base = (ct == pmfr_pkg::CT_STANDARD) ? 4'(pmfr_pkg::IDX_STD_BASE)
                                                             : 4'(pmfr_pkg::IDX_ENV_BASE);
                        if (sz == pmfr_pkg::SIZE_1P0)
                            sel = base;
                        else if (sz == pmfr_pkg::SIZE_2P5)
                            sel = base + 1;
                        else if (sz == pmfr_pkg::SIZE_10)
                            sel = base + 2;
                    end
                    else if (kind == pmfr_pkg::KIND_COUNT && sz >= pmfr_pkg::SIZE_MIN &&
                             sz <= pmfr_pkg::SIZE_MAX)
                        sel = int'(sz) + int'(pmfr_pkg::IDX_COUNT_OFFS);
                    if (sel < 0 || sel >= pmfr_pkg::NUM_READINGS)
                        queue_report(pmfr_pkg::ST_UNSUPPORTED, '0, '0, 1'b1);
                    else
                        queue_report(pmfr_pkg::ST_VALUE, latched[sel], 4'(sel), 1'b1);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic send_item(pmfr_pkg::opcode_t op, logic [7:0] b, pmfr_pkg::kind_t kind,
                             pmfr_pkg::ctype_t ct, logic [2:0] sz);
        int gap;
        gap = idling ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid           <= 1'b1;
        opcode             <= op;
        rx_byte            <= b;
        metric_kind        <= kind;
        concentration_type <= ct;
        particle_size      <= sz;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        predict_reports(op, b, kind, ct, sz);
        if (op != pmfr_pkg::OP_NONE)
            sent_items++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(pmfr_pkg::OP_BYTE, b, pmfr_pkg::kind_t'($urandom_range(0, 3)),
                  pmfr_pkg::ctype_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
    endtask

    task automatic send_tick();
        send_item(pmfr_pkg::OP_TICK, 8'($urandom), pmfr_pkg::kind_t'($urandom_range(0, 3)),
                  pmfr_pkg::ctype_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
    endtask

    task automatic send_query(pmfr_pkg::kind_t kind, pmfr_pkg::ctype_t ct, logic [2:0] sz);
        send_item(pmfr_pkg::OP_QUERY, 8'($urandom), kind, ct, sz);
    endtask

    // half fully random, half drawn from the supported combinations
    task automatic random_query();
        pmfr_pkg::kind_t  kind;
        pmfr_pkg::ctype_t ct;
        logic [2:0]       sz;
        if ($urandom_range(0, 1) == 0)
        begin
            kind = pmfr_pkg::kind_t'($urandom_range(0, 3));
            ct   = pmfr_pkg::ctype_t'($urandom_range(0, 3));
            sz   = 3'($urandom_range(0, 7));
        end
        else
        begin
            kind = pmfr_pkg::kind_t'($urandom_range(0, 2));
            ct   = pmfr_pkg::ctype_t'($urandom_range(1, 2));
            sz   = 3'($urandom_range(pmfr_pkg::SIZE_MIN, pmfr_pkg::SIZE_MAX));
            if (kind == pmfr_pkg::KIND_MASS)
            begin
                case ($urandom_range(0, 2))
                    0:       sz = pmfr_pkg::SIZE_1P0;
                    1:       sz = pmfr_pkg::SIZE_2P5;
                    default: sz = pmfr_pkg::SIZE_10;
                endcase
            end
        end
        send_query(kind, ct, sz);
    endtask

    task automatic build_frame(fill_t fill, bit corrupt);
        logic [15:0] sum;
        frame_img[0] = pmfr_pkg::HDR_FIRST;
        frame_img[1] = pmfr_pkg::HDR_SECOND;
        for (int i = 2; i < pmfr_pkg::FRAME_BYTES - 2; i++)
        begin
            case (fill)
                FILL_ONES:  frame_img[i] = 8'hFF;
                FILL_ZEROS: frame_img[i] = 8'h00;
                default:    frame_img[i] = 8'($urandom);
            endcase
        end
        sum = '0;
        for (int i = 0; i < pmfr_pkg::FRAME_BYTES - 2; i++)
            sum = sum + 16'(frame_img[i]);
        if (corrupt)
            sum = sum ^ 16'($urandom_range(1, 65535));
        {frame_img[pmfr_pkg::FRAME_BYTES-2], frame_img[pmfr_pkg::FRAME_BYTES-1]} = sum;
    endtask

    // stir_pct: chance of a tick or query slipped in before each byte
    task automatic send_frame(fill_t fill, bit corrupt, int nbytes, int stir_pct);
        build_frame(fill, corrupt);
        for (int i = 0; i < nbytes; i++)
        begin
            if ($urandom_range(0, 99) < stir_pct)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_tick();
                else
                    random_query();
            end
            send_byte(frame_img[i]);
        end
    endtask

    // register writes only once the block has gone quiet
    task automatic set_timeout(logic [15:0] value);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        timeout_ticks_we    <= 1'b1;
        timeout_ticks_wdata <= value;
        @(posedge clk);
        timeout_ticks_we <= 1'b0;
        timeout_limit = value;
    endtask

    task automatic test_no_data_queries();
        send_query(pmfr_pkg::KIND_ALL, pmfr_pkg::CT_NONE, 3'd0);
        send_query(pmfr_pkg::KIND_MASS, pmfr_pkg::CT_STANDARD, pmfr_pkg::SIZE_1P0);
        send_query(pmfr_pkg::KIND_BAD, pmfr_pkg::CT_BAD, 3'd7);
        send_item(pmfr_pkg::OP_NONE, 8'hFF, pmfr_pkg::KIND_BAD, pmfr_pkg::CT_BAD, 3'd7);
        send_tick();
        send_tick();
    endtask

    task automatic test_header_hunt();
        send_byte(8'h00);
        send_byte(pmfr_pkg::HDR_SECOND);
        send_byte(pmfr_pkg::HDR_FIRST);
        send_byte(8'h00);
        send_byte(pmfr_pkg::HDR_FIRST);
        send_byte(pmfr_pkg::HDR_FIRST);
        send_byte(pmfr_pkg::HDR_SECOND);
        send_byte(8'hFF);
    endtask

    task automatic test_frame_outcomes();
        send_frame(FILL_ONES, 1'b0, pmfr_pkg::FRAME_BYTES, 0);
        send_query(pmfr_pkg::KIND_ALL, pmfr_pkg::CT_NONE, 3'd0);
        send_query(pmfr_pkg::KIND_MASS, pmfr_pkg::CT_ENV, pmfr_pkg::SIZE_10);
        send_query(pmfr_pkg::KIND_MASS, pmfr_pkg::CT_STANDARD, pmfr_pkg::SIZE_2P5);
        send_query(pmfr_pkg::KIND_COUNT, pmfr_pkg::CT_NONE, pmfr_pkg::SIZE_MIN);
        send_query(pmfr_pkg::KIND_COUNT, pmfr_pkg::CT_BAD, pmfr_pkg::SIZE_MAX);
        send_query(pmfr_pkg::KIND_MASS, pmfr_pkg::CT_NONE, pmfr_pkg::SIZE_2P5);
        send_query(pmfr_pkg::KIND_MASS, pmfr_pkg::CT_STANDARD, 3'd5);
        send_query(pmfr_pkg::KIND_COUNT, pmfr_pkg::CT_NONE, 3'd0);
        send_query(pmfr_pkg::KIND_COUNT, pmfr_pkg::CT_ENV, 3'd7);
        send_query(pmfr_pkg::KIND_BAD, pmfr_pkg::CT_STANDARD, pmfr_pkg::SIZE_1P0);
        // bad checksum keeps the earlier readings
        send_frame(FILL_ZEROS, 1'b1, pmfr_pkg::FRAME_BYTES, 0);
        send_query(pmfr_pkg::KIND_ALL, pmfr_pkg::CT_NONE, 3'd0);
        send_frame(FILL_ZEROS, 1'b0, pmfr_pkg::FRAME_BYTES, 0);
        send_query(pmfr_pkg::KIND_MASS, pmfr_pkg::CT_STANDARD, pmfr_pkg::SIZE_1P0);
    endtask

    task automatic test_timeout();
        set_timeout(16'd3);
        send_frame(FILL_RANDOM, 1'b0, 5, 0);
        repeat (3) send_tick();
        send_frame(FILL_RANDOM, 1'b0, pmfr_pkg::FRAME_BYTES, 0);
        set_timeout(16'd10);
        repeat (5) send_tick();
        // limit dropped below the running count
        set_timeout(16'd2);
        send_tick();
        set_timeout(16'd1);
        repeat (2) send_tick();
    endtask

    task automatic test_backpressure();
        idling       = 1'b0;
        hold_off_req = HOLD_OFF;
        repeat (6) send_query(pmfr_pkg::KIND_ALL, pmfr_pkg::CT_NONE, 3'd0);
        repeat (10) random_query();
        idling = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [15:0] limits [4];
        int          goal;
        int          pick;
        limits[0] = 16'd1;
        limits[1] = 16'($urandom_range(2, 40));
        limits[2] = 16'hFFFF;
        limits[3] = 16'($urandom_range(100, 1000));
        for (int phase = 0; phase < 4; phase++)
        begin
            set_timeout(limits[phase]);
            idling = (phase != 2);
            goal   = sent_items + RANDOM_ITEMS / 4;
            while (sent_items < goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    send_frame(FILL_RANDOM, $urandom_range(0, 4) == 0,
                               pmfr_pkg::FRAME_BYTES, 5);
                else if (pick < 55)
                    send_frame(FILL_RANDOM, 1'b0,
                               $urandom_range(1, pmfr_pkg::FRAME_BYTES - 1), 0);
                else if (pick < 65)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_byte(pmfr_pkg::HDR_FIRST);
                    send_byte(8'($urandom));
                end
                else if (pick < 85)
                    random_query();
                else if (pick < 95)
                    repeat ($urandom_range(1, 4)) send_tick();
                else
                    send_item(pmfr_pkg::OP_NONE, 8'($urandom),
                              pmfr_pkg::kind_t'($urandom_range(0, 3)),
                              pmfr_pkg::ctype_t'($urandom_range(0, 3)),
                              3'($urandom_range(0, 7)));
            end
        end
    endtask

    initial
    begin
        int wait_cycles;
        out_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_req > 0)
            begin
                wait_cycles  = hold_off_req;
                hold_off_req = 0;
            end
            else
                wait_cycles = idling ? $urandom_range(0, 16) : 0;
            if (wait_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            result_beats++;
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected beat, got status %0d reading %0h index %0d last %0b",
                         $time, status, reading, reading_index, last);
            end
            else
            begin
                head = pending_reports.pop_front();
                if (status !== head.st || reading !== head.value ||
                    reading_index !== head.idx || last !== head.fin)
                begin
                    mismatches++;
                    $display("%0t: expected status %0d reading %0h index %0d last %0b",
                             $time, head.st, head.value, head.idx, head.fin);
                    $display("%0t: actual   status %0d reading %0h index %0d last %0b",
                             $time, status, reading, reading_index, last);
                end
            end
        end
    end

    initial
    begin
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_ready === 1'b1) ||
                (out_valid === 1'b1 && out_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        timeout_ticks_we    = 1'b0;
        timeout_ticks_wdata = '0;
        in_valid            = 1'b0;
        opcode              = '0;
        rx_byte             = '0;
        metric_kind         = '0;
        concentration_type  = '0;
        particle_size       = '0;
        idling              = 1'b1;
        hold_off_req        = 0;
        sent_items          = 0;
        result_beats        = 0;
        mismatches          = 0;
        good_frames         = 0;
        bad_frames          = 0;
        timeouts            = 0;
        have_frame          = 1'b0;
        timeout_limit       = pmfr_pkg::TIMEOUT_RESET;
        restart_frame();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_no_data_queries();
        test_header_hunt();
        test_frame_outcomes();
        test_timeout();
        test_backpressure();
        test_random_traffic();

        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d input beats and %0d result beats", sent_items, result_beats);
        $display("Frames: %0d good, %0d checksum errors; %0d timeouts; %0d mismatches",
                 good_frames, bad_frames, timeouts, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
